// ===== hdl/arp_pkg.sv =====
package arp_pkg;

	// Fixed arithmetic formats of the policy.
	localparam int SIZE_BITS = 48;
	localparam int FRAC_BITS = 16;
	localparam int VAL_W = 48;
	localparam int COST_W = 56;
	localparam int BYTES_W = 32;
	localparam int ALPHA_W = 17;
	localparam int FACTOR_W = 16;
	localparam int ALPHA_SHIFT = 16;
	localparam int FACTOR_SHIFT = 8;
	localparam int PROD_W = VAL_W + ALPHA_W;

	// Long division: one quotient bit per step.
	localparam int DIV_STEPS = VAL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Result word: reset flag, marginal cost, marginal baseline, baseline flag,
	// cost average, spawn count, last reset size, zero padded to whole bytes.
	localparam int OUT_BITS = 1 + VAL_W + VAL_W + 1 + VAL_W + 32 + VAL_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_W = ((SIZE_BITS + BYTES_W + 7) / 8) * 8;

	// Decision modes.
	localparam logic [1:0] MODE_GRAD = 2'd0;
	localparam logic [1:0] MODE_EMA = 2'd1;
	localparam logic [1:0] MODE_HYBRID = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_WINDOW = 3'd1;
	localparam logic [2:0] REG_ALPHA = 3'd2;
	localparam logic [2:0] REG_GFACT = 3'd3;
	localparam logic [2:0] REG_EFACT = 3'd4;
	localparam logic [2:0] REG_MIN = 3'd5;
	localparam logic [2:0] REG_MAX = 3'd6;

	typedef struct packed {
		logic load;
		logic push;
		logic ema_upd;
		logic div_init;
		logic div_step;
		logic base;
		logic mul_g;
		logic mul_e;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== hdl/adaptive_reset_policy_top.sv =====
// Each accepted request is worked on alone, and the 48-step restoring divider
// for the marginal cost is most of its work. The next request is taken as soon
// as the result is in the output register; the result waits to go there while
// the previous result has not been taken by the result side.
// Reset: arst_n clears the controller, tree state and configuration registers
// at once; the window memory is not cleared and is only read where written.
module adaptive_reset_policy_top #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Input requests. s_tdata: tree size [47:0], written bytes [79:48].
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [arp_pkg::IN_W-1:0] s_tdata,
	// Results. m_tdata: reset_now [0], marginal_cost [48:1],
	// baseline_marginal [96:49], baseline_valid [97], cost average [145:98],
	// spawn count [177:146], last_reset_size [225:178], zeros above.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [arp_pkg::OUT_W-1:0] m_tdata,
	// Configuration port, one 64-bit register every eight bytes.
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [5:0]               paddr,
	input  logic [63:0]              pwdata,
	output logic [63:0]              prdata,
	output logic                     pready
);
	import arp_pkg::*;

	logic [1:0]          mode_q;
	logic [6:0]          window_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [FACTOR_W-1:0] gfact_q;
	logic [FACTOR_W-1:0] efact_q;
	logic [VAL_W-1:0]    min_q;
	logic [VAL_W-1:0]    max_q;
	logic [2:0]          reg_idx;
	logic                cfg_wr;
	cmd_t                cmd;
	status_t             stat;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr = psel && penable && pwrite && pready;

	// The user must write registers only while the block holds no request; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GRAD;
			window_q <= 7'd16;
			alpha_q <= 17'd6554;
			gfact_q <= 16'd512;
			efact_q <= 16'd512;
			min_q <= '0;
			max_q <= '1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE:   mode_q <= pwdata[1:0];
				REG_WINDOW: window_q <= pwdata[6:0];
				REG_ALPHA:  alpha_q <= pwdata[ALPHA_W-1:0];
				REG_GFACT:  gfact_q <= pwdata[FACTOR_W-1:0];
				REG_EFACT:  efact_q <= pwdata[FACTOR_W-1:0];
				REG_MIN:    min_q <= pwdata[VAL_W-1:0];
				REG_MAX:    max_q <= pwdata[VAL_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:   prdata = 64'(mode_q);
			REG_WINDOW: prdata = 64'(window_q);
			REG_ALPHA:  prdata = 64'(alpha_q);
			REG_GFACT:  prdata = 64'(gfact_q);
			REG_EFACT:  prdata = 64'(efact_q);
			REG_MIN:    prdata = 64'(min_q);
			REG_MAX:    prdata = 64'(max_q);
			default:    prdata = '0;
		endcase
	end

	// The controller sequences push, EMA update, division, baseline latch,
	// the two threshold products and the final decision.
	arp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	arp_datapath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.mode            (mode_q),
		.window_len      (window_q),
		.alpha_cfg       (alpha_q),
		.gradient_factor (gfact_q),
		.ema_factor      (efact_q),
		.min_size        (min_q),
		.max_size        (max_q),
		.in_size         (s_tdata[SIZE_BITS-1:0]),
		.in_bytes        (s_tdata[SIZE_BITS +: BYTES_W]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_data        (m_tdata),
		.stat            (stat)
	);

	// A request is worked on alone: the port closes right after acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a request was in progress");

	// A reset decision clears the EMA and the baselines in the same result.
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[97] && m_tdata[145:98] == '0 &&
		m_tdata[96:49] == '0 && m_tdata[48:1] == '0)
		else $error("reset result carries stale tree state");

	// The spawn count moves only on a delivered reset decision.
	a_spawn_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid && $changed(m_tdata[177:146]) |->
		m_tdata[0])
		else $error("spawn count changed without a reset");

endmodule

// ===== hdl/arp_ctrl.sv =====
module arp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  arp_pkg::status_t stat,
	output arp_pkg::cmd_t    cmd
);
	import arp_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_PUSH = 9'b000000010,
		ST_EMA  = 9'b000000100,
		ST_DIVI = 9'b000001000,
		ST_DIV  = 9'b000010000,
		ST_BASE = 9'b000100000,
		ST_MG   = 9'b001000000,
		ST_ME   = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d = ST_EMA;
			end
			ST_EMA: begin
				cmd.ema_upd = 1'b1;
				state_d = ST_DIVI;
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_BASE;
			end
			ST_BASE: begin
				cmd.base = 1'b1;
				state_d = ST_MG;
			end
			ST_MG: begin
				cmd.mul_g = 1'b1;
				state_d = ST_ME;
			end
			ST_ME: begin
				cmd.mul_e = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = stat.out_free;
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

endmodule

// ===== hdl/arp_datapath.sv =====
module arp_datapath #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  arp_pkg::cmd_t                 cmd,
	input  logic [1:0]                    mode,
	input  logic [6:0]                    window_len,
	input  logic [arp_pkg::ALPHA_W-1:0]   alpha_cfg,
	input  logic [arp_pkg::FACTOR_W-1:0]  gradient_factor,
	input  logic [arp_pkg::FACTOR_W-1:0]  ema_factor,
	input  logic [arp_pkg::VAL_W-1:0]     min_size,
	input  logic [arp_pkg::VAL_W-1:0]     max_size,
	input  logic [arp_pkg::SIZE_BITS-1:0] in_size,
	input  logic [arp_pkg::BYTES_W-1:0]   in_bytes,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [arp_pkg::OUT_W-1:0]     out_data,
	output arp_pkg::status_t              stat
);
	import arp_pkg::*;

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int HW = AW + 2;
	localparam int MEM_W = COST_W + SIZE_BITS;

	logic [MEM_W-1:0] ring_mem [WINDOW_MAX];

	logic [SIZE_BITS-1:0] size_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic [COST_W-1:0]    cum_q;
	logic [31:0]          ev_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [MEM_W-1:0]     rd_q;
	logic [PROD_W-1:0]    prod_q;
	logic [VAL_W-1:0]     ema_q;
	logic [SIZE_BITS-1:0] ds_q;
	logic                 mzero_q;
	logic                 ovf_q;
	logic [SIZE_BITS:0]   rem_q;
	logic [VAL_W-1:0]     dl_q;
	logic [VAL_W-1:0]     quo_q;
	logic [VAL_W-1:0]     marg_q;
	logic [VAL_W-1:0]     base_m_q;
	logic [VAL_W-1:0]     base_e_q;
	logic                 bv_q;
	logic                 g_q;
	logic [31:0]          spawn_q;
	logic [VAL_W-1:0]     rsz_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_q;

	logic [CW-1:0]        w_c;
	logic [COST_W:0]      cum_sum;
	logic [COST_W-1:0]    cum_new;
	logic [CW-1:0]        drop_c;
	logic [HW-1:0]        hsum_c;
	logic [AW-1:0]        head_pop;
	logic [HW-1:0]        ssum_c;
	logic [AW-1:0]        slot_c;
	logic [VAL_W-1:0]     sample_c;
	logic [ALPHA_W-1:0]   alpha_c;
	logic [VAL_W-1:0]     mul_a;
	logic [ALPHA_W-1:0]   mul_b;
	logic [PROD_W-1:0]    prod_c;
	logic [PROD_W:0]      ema_sum;
	logic [SIZE_BITS-1:0] ds_c;
	logic [COST_W-1:0]    dc_c;
	logic [SIZE_BITS:0]   trial_c;
	logic                 qbit_c;
	logic [VAL_W-1:0]     marg_c;
	logic                 e_c;
	logic                 rst_c;
	logic [31:0]          spawn_n;
	logic [VAL_W-1:0]     rsz_n;

	// Window length clamped to one through the ring depth.
	always_comb begin
		if (window_len == 7'd0) w_c = CW'(1);
		else if (32'(window_len) > 32'(WINDOW_MAX)) w_c = CW'(WINDOW_MAX);
		else w_c = CW'(window_len);
	end

	assign cum_sum = (COST_W + 1)'(cum_q) + (COST_W + 1)'(in_bytes);
	assign cum_new = cum_sum[COST_W] ? '1 : cum_sum[COST_W-1:0];

	// Drop the oldest entries so that the push leaves at most w entries.
	assign drop_c = count_q - w_c + CW'(1);
	assign hsum_c = HW'(head_q) + HW'(drop_c);
	assign head_pop = (hsum_c >= HW'(WINDOW_MAX)) ? AW'(hsum_c - HW'(WINDOW_MAX)) : AW'(hsum_c);
	assign ssum_c = HW'(head_q) + HW'(count_q);
	assign slot_c = (ssum_c >= HW'(WINDOW_MAX)) ? AW'(ssum_c - HW'(WINDOW_MAX)) : AW'(ssum_c);

	assign sample_c = {bytes_q, {FRAC_BITS{1'b0}}};
	assign alpha_c = (alpha_cfg > ALPHA_W'(1 << ALPHA_SHIFT)) ? ALPHA_W'(1 << ALPHA_SHIFT)
	                                                        : alpha_cfg;

	// One shared multiplier for the EMA terms and both threshold products.
	always_comb begin
		if (cmd.push) begin
			mul_a = sample_c;
			mul_b = alpha_c;
		end else if (cmd.ema_upd) begin
			mul_a = ema_q;
			mul_b = ALPHA_W'(1 << ALPHA_SHIFT) - alpha_c;
		end else if (cmd.mul_g) begin
			mul_a = base_m_q;
			mul_b = {1'b0, gradient_factor};
		end else begin
			mul_a = base_e_q;
			mul_b = {1'b0, ema_factor};
		end
	end
	assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign ema_sum = (PROD_W + 1)'(prod_q) + (PROD_W + 1)'(prod_c);

	assign ds_c = size_q - rd_q[SIZE_BITS-1:0];
	assign dc_c = cum_q - rd_q[MEM_W-1:SIZE_BITS];

	assign trial_c = {rem_q[SIZE_BITS-1:0], dl_q[VAL_W-1]};
	assign qbit_c = (trial_c >= {1'b0, ds_q});

	assign marg_c = mzero_q ? '0 : (ovf_q ? '1 : quo_q);

	assign e_c = ({10'b0, ema_q, {FACTOR_SHIFT{1'b0}}} > (PROD_W + 1)'(prod_q));

	always_comb begin
		if (size_q < min_size) rst_c = 1'b0;
		else if (size_q > max_size) rst_c = 1'b1;
		else if (bv_q) begin
			case (mode)
				MODE_GRAD:   rst_c = g_q;
				MODE_EMA:    rst_c = e_c;
				MODE_HYBRID: rst_c = g_q && e_c;
				default:     rst_c = 1'b0;
			endcase
		end else rst_c = 1'b0;
	end

	assign spawn_n = rst_c ? spawn_q + 32'd1 : spawn_q;
	assign rsz_n = rst_c ? VAL_W'(size_q) : rsz_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_mem[slot_c] <= {cum_q, size_q};
			rd_q <= ring_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q <= '0;
			ev_q <= '0;
			head_q <= '0;
			count_q <= '0;
			ema_q <= '0;
			base_m_q <= '0;
			base_e_q <= '0;
			bv_q <= 1'b0;
			spawn_q <= '0;
			rsz_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (ev_q != '1) ev_q <= ev_q + 32'd1;
				cum_q <= cum_new;
				if (count_q >= w_c) begin
					head_q <= head_pop;
					count_q <= w_c - CW'(1);
				end
			end
			if (cmd.push) count_q <= count_q + CW'(1);
			if (cmd.ema_upd) begin
				if (ema_q == '0) ema_q <= sample_c;
				else ema_q <= ema_sum[ALPHA_SHIFT +: VAL_W];
			end
			if (cmd.base && ev_q == 32'(w_c)) begin
				base_m_q <= marg_c;
				base_e_q <= ema_q;
				bv_q <= 1'b1;
			end
			if (cmd.finish) begin
				spawn_q <= spawn_n;
				rsz_q <= rsz_n;
				if (rst_c) begin
					head_q <= '0;
					count_q <= '0;
					cum_q <= '0;
					ema_q <= '0;
					base_m_q <= '0;
					base_e_q <= '0;
					bv_q <= 1'b0;
					ev_q <= '0;
				end
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q <= in_size;
			bytes_q <= in_bytes;
		end
		if (cmd.push) prod_q <= prod_c;
		if (cmd.div_init) begin
			ds_q <= ds_c;
			mzero_q <= (count_q < CW'(2)) || (ds_c == '0);
			ovf_q <= ({24'b0, dc_c} >= {ds_c, 32'b0});
			rem_q <= (SIZE_BITS + 1)'(dc_c[COST_W-1:VAL_W-FRAC_BITS]);
			dl_q <= {dc_c[VAL_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= qbit_c ? trial_c - {1'b0, ds_q} : trial_c;
			dl_q <= {dl_q[VAL_W-2:0], 1'b0};
			quo_q <= {quo_q[VAL_W-2:0], qbit_c};
		end
		if (cmd.base) marg_q <= marg_c;
		if (cmd.mul_g) prod_q <= prod_c;
		if (cmd.mul_e) begin
			prod_q <= prod_c;
			g_q <= ({10'b0, marg_q, {FACTOR_SHIFT{1'b0}}} > (PROD_W + 1)'(prod_q));
		end
		if (cmd.finish) begin
			out_q <= OUT_W'({rsz_n, spawn_n, (rst_c ? '0 : ema_q), (rst_c ? 1'b0 : bv_q),
			                 (rst_c ? '0 : base_m_q), (rst_c ? '0 : marg_q), rst_c});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

// ===== verif/adaptive_reset_policy_top_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the adaptive tree-reset policy block.
// A short table of compaction events exercises the guardrails and the corner
// cases of the marginal-cost and average arithmetic. It is followed by phases
// of random events under several register settings. Every accepted request is
// run through a local model of the policy, and each result is compared field
// by field with the oldest prediction still waiting.
module adaptive_reset_policy_top_tb;
	import arp_pkg::*;

	localparam logic [1:0] MODE_OFF = 2'd3;
	localparam logic [47:0] SIZE_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [55:0] COST_SAT = 56'hFF_FFFF_FFFF_FFFF;
	localparam int RING_DEPTH = 64;
	localparam int CYCLE_LIMIT = 900000;
	localparam int HOLD_CYCLES = 400;

	// Lowest field last, matching the result word on m_tdata.
	typedef struct packed {
		logic [47:0] last_reset_size;
		logic [31:0] spawn_total;
		logic [47:0] cost_average;
		logic        baseline_valid;
		logic [47:0] baseline_marginal;
		logic [47:0] marginal_cost;
		logic        reset_now;
	} decision_t;

	typedef struct {
		logic [47:0] size;
		logic [31:0] bytes;
		bit          known;
		bit          want_reset;
	} event_row_t;

	typedef struct {
		logic [1:0]  mode;
		logic [6:0]  win;
		logic [16:0] alpha;
		logic [15:0] gfact;
		logic [15:0] efact;
		logic [47:0] min_sz;
		logic [47:0] max_sz;
		int          count;
		bit          calm;
		bit          squeeze;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	adaptive_reset_policy_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the policy registers and of the per-tree state.
	logic [1:0]  pol_mode;
	logic [6:0]  pol_win;
	logic [16:0] pol_alpha;
	logic [15:0] pol_gfact, pol_efact;
	logic [47:0] pol_min, pol_max;
	logic [47:0] size_hist [RING_DEPTH];
	logic [55:0] cost_hist [RING_DEPTH];
	int          hist_head, hist_count;
	logic [55:0] cost_total;
	logic [47:0] avg_cost, base_marg, base_avg;
	logic        base_set;
	logic [31:0] tree_events, spawned;
	logic [47:0] spawn_size;

	decision_t pending_decisions[$];
	int  errors = 0;
	int  cycles = 0;
	int  results_seen = 0;
	int  resets_seen = 0;
	bit  calm = 1'b0;       // no idling on either side while set
	bit  hold_req = 1'b0;   // asks the result side for one long hold-off
	int  hold_left = 0;

	function automatic void clear_tree_model();
		hist_head = 0;
		hist_count = 0;
		cost_total = '0;
		avg_cost = '0;
		base_marg = '0;
		base_avg = '0;
		base_set = 1'b0;
		tree_events = '0;
	endfunction

	// Cost slope between the oldest and newest window entries, Q32.16.
	function automatic logic [47:0] slope_now();
		int oldest, newest;
		logic [47:0] ds;
		logic [55:0] dc;
		logic [79:0] quot;
		if (hist_count < 2)
			return '0;
		oldest = hist_head % RING_DEPTH;
		newest = (hist_head + hist_count - 1) % RING_DEPTH;
		ds = size_hist[newest] - size_hist[oldest];
		if (ds == 0)
			return '0;
		dc = cost_hist[newest] - cost_hist[oldest];
		quot = ({24'd0, dc} << 16) / {32'd0, ds};
		return (quot > {32'd0, SIZE_MAX}) ? SIZE_MAX : quot[47:0];
	endfunction

	function automatic bit exceeds(logic [47:0] v, logic [47:0] base, logic [15:0] factor);
		logic [63:0] lhs, rhs;
		lhs = {16'd0, v} << 8;
		rhs = {16'd0, base} * {48'd0, factor};
		return lhs > rhs;
	endfunction

	function automatic decision_t decide_event(logic [47:0] size, logic [31:0] bytes);
		int win, slot;
		logic [56:0] sum;
		logic [47:0] sample, marg;
		logic [79:0] alpha, blend;
		bit do_reset, g_hit, e_hit;
		decision_t d;
		win = (pol_win < 1) ? 1 : (pol_win > RING_DEPTH) ? RING_DEPTH : int'(pol_win);
		do_reset = 1'b0;
		if (tree_events != 32'hFFFF_FFFF)
			tree_events++;
		sum = {1'b0, cost_total} + {25'd0, bytes};
		cost_total = sum[56] ? COST_SAT : sum[55:0];
		while (hist_count >= win) begin
			hist_head = (hist_head + 1) % RING_DEPTH;
			hist_count--;
		end
		slot = (hist_head + hist_count) % RING_DEPTH;
		size_hist[slot] = size;
		cost_hist[slot] = cost_total;
		hist_count++;
		sample = (bytes > 32'hFFFF_FFFF) ? SIZE_MAX : {bytes, 16'd0};
		alpha = (pol_alpha > 17'd65536) ? 80'd65536 : {63'd0, pol_alpha};
		if (avg_cost == 0) begin
			avg_cost = sample;
		end else begin
			blend = alpha * sample + (80'd65536 - alpha) * avg_cost;
			avg_cost = blend[63:16];
		end
		marg = slope_now();
		if (tree_events == win) begin
			base_marg = marg;
			base_avg = avg_cost;
			base_set = 1'b1;
		end
		if (size < pol_min) begin
			do_reset = 1'b0;
		end else if (size > pol_max) begin
			do_reset = 1'b1;
		end else if (base_set) begin
			g_hit = exceeds(marg, base_marg, pol_gfact);
			e_hit = exceeds(avg_cost, base_avg, pol_efact);
			case (pol_mode)
				MODE_GRAD: do_reset = g_hit;
				MODE_EMA: do_reset = e_hit;
				MODE_HYBRID: do_reset = g_hit && e_hit;
				default: do_reset = 1'b0;
			endcase
		end
		if (do_reset) begin
			spawned++;
			spawn_size = size;
			clear_tree_model();
			marg = '0;
		end
		d.reset_now = do_reset;
		d.marginal_cost = marg;
		d.baseline_marginal = base_marg;
		d.baseline_valid = base_set;
		d.cost_average = avg_cost;
		d.spawn_total = spawned;
		d.last_reset_size = spawn_size;
		return d;
	endfunction

	// Register write: setup cycle, then access cycle; the write lands on the
	// edge that ends the access cycle. The shadow copy follows at once.
	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE: pol_mode = value[1:0];
			REG_WINDOW: pol_win = value[6:0];
			REG_ALPHA: pol_alpha = value[16:0];
			REG_GFACT: pol_gfact = value[15:0];
			REG_EFACT: pol_efact = value[15:0];
			REG_MIN: pol_min = value[47:0];
			REG_MAX: pol_max = value[47:0];
			default: ;
		endcase
	endtask

	// Waits for every outstanding result, then lets the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_phase(phase_t p);
		write_reg(REG_MODE, {62'd0, p.mode});
		write_reg(REG_WINDOW, {57'd0, p.win});
		write_reg(REG_ALPHA, {47'd0, p.alpha});
		write_reg(REG_GFACT, {48'd0, p.gfact});
		write_reg(REG_EFACT, {48'd0, p.efact});
		write_reg(REG_MIN, {16'd0, p.min_sz});
		write_reg(REG_MAX, {16'd0, p.max_sz});
	endtask

	// Offers one compaction event and predicts its result on acceptance.
	// Valid is only lowered when an idle gap is actually inserted, so it
	// never gets two assignments in the same step.
	task automatic offer_event(logic [47:0] size, logic [31:0] bytes, output decision_t d);
		if (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {bytes, size};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		d = decide_event(size, bytes);
		pending_decisions.insert(pending_decisions.size(), d);
	endtask

	// Result side: checks on each handshake, then picks the next ready value.
	always @(posedge clk) begin
		decision_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = decision_t'(m_tdata[225:0]);
			results_seen++;
			if (got.reset_now)
				resets_seen++;
			if (pending_decisions.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = pending_decisions[0];
				pending_decisions.delete(0);
				if (got.reset_now !== want.reset_now) begin
					$error("reset_now: expected %0d, got %0d", want.reset_now, got.reset_now);
					errors++;
				end
				if (got.marginal_cost !== want.marginal_cost) begin
					$error("marginal_cost: expected %h, got %h",
						want.marginal_cost, got.marginal_cost);
					errors++;
				end
				if (got.baseline_marginal !== want.baseline_marginal) begin
					$error("baseline_marginal: expected %h, got %h",
						want.baseline_marginal, got.baseline_marginal);
					errors++;
				end
				if (got.baseline_valid !== want.baseline_valid) begin
					$error("baseline_valid: expected %0d, got %0d",
						want.baseline_valid, got.baseline_valid);
					errors++;
				end
				if (got.cost_average !== want.cost_average) begin
					$error("cost_average: expected %h, got %h",
						want.cost_average, got.cost_average);
					errors++;
				end
				if (got.spawn_total !== want.spawn_total) begin
					$error("spawn_total: expected %0d, got %0d",
						want.spawn_total, got.spawn_total);
					errors++;
				end
				if (got.last_reset_size !== want.last_reset_size) begin
					$error("last_reset_size: expected %h, got %h",
						want.last_reset_size, got.last_reset_size);
					errors++;
				end
			end
		end
		// A long hold-off lets the block fill up and push back on its input.
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Directed events. The first rows run under the reset settings; the rest
	// under a narrow window with both size guardrails in reach. Only rows whose
	// decision is obvious carry an expected reset flag of their own.
	event_row_t directed [] = '{
		'{48'd0, 32'd0, 1'b1, 1'b0},
		'{SIZE_MAX, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{48'd5, 32'd1, 1'b0, 1'b0},
		'{48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0},
		// Narrow window, min 0x100, max 0xFFFF_0000_0000 from here on.
		'{48'h10, 32'd100, 1'b1, 1'b0},
		'{SIZE_MAX, 32'd7, 1'b1, 1'b1},
		'{48'h1000, 32'd50, 1'b0, 1'b0},
		'{48'h1000, 32'd60, 1'b0, 1'b0},
		'{48'h0800, 32'd70, 1'b0, 1'b0},
		'{48'h2000, 32'hFFFF_FFFF, 1'b0, 1'b0},
		'{48'h2001, 32'hFFFF_FFFF, 1'b0, 1'b0},
		'{48'h3000, 32'd0, 1'b0, 1'b0},
		'{48'h3000, 32'd0, 1'b0, 1'b0},
		'{48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0},
		'{48'hFFFF_0000_0000, 32'd1, 1'b0, 1'b0},
		'{48'hFFFF_0000_0001, 32'd1, 1'b1, 1'b1},
		'{48'h0100, 32'd1, 1'b0, 1'b0},
		'{48'h00FF, 32'd2, 1'b1, 1'b0},
		'{48'h0200, 32'd4000, 1'b0, 1'b0},
		'{48'h0300, 32'd9000, 1'b0, 1'b0}
	};

	phase_t phases [] = '{
		'{MODE_GRAD, 7'd8, 17'd6554, 16'd384, 16'd512, 48'd0, SIZE_MAX, 140, 1'b1, 1'b0},
		'{MODE_EMA, 7'd16, 17'd20000, 16'd512, 16'd300, 48'd0, SIZE_MAX, 140, 1'b0, 1'b1},
		'{MODE_HYBRID, 7'd4, 17'd65536, 16'd300, 16'd300, 48'h1000, SIZE_MAX,
			140, 1'b0, 1'b0},
		'{MODE_OFF, 7'd0, 17'h1FFFF, 16'd0, 16'd0, 48'd0, 48'hFFFF_FFFF_0000,
			140, 1'b0, 1'b0},
		'{MODE_GRAD, 7'd127, 17'd1, 16'hFFFF, 16'hFFFF, 48'd0, SIZE_MAX, 140, 1'b0, 1'b0},
		'{MODE_EMA, 7'd64, 17'd0, 16'd256, 16'd256, 48'd0, 48'h8000_0000, 140, 1'b0, 1'b0},
		'{MODE_GRAD, 7'd1, 17'd65535, 16'd0, 16'hFFFF, SIZE_MAX, SIZE_MAX, 140, 1'b0, 1'b0},
		'{MODE_HYBRID, 7'd2, 17'd30000, 16'd400, 16'd400, 48'd0, SIZE_MAX,
			140, 1'b0, 1'b0}
	};

	initial begin
		decision_t d;
		logic [47:0] cur_size;
		logic [31:0] cur_bytes;
		int step_cost;
		int sent;

		pol_mode = MODE_GRAD;
		pol_win = 7'd16;
		pol_alpha = 17'd6554;
		pol_gfact = 16'd512;
		pol_efact = 16'd512;
		pol_min = '0;
		pol_max = SIZE_MAX;
		clear_tree_model();
		spawned = '0;
		spawn_size = '0;
		sent = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) begin
			if (i == 4) begin
				drain();
				write_reg(REG_WINDOW, 64'd4);
				write_reg(REG_MIN, 64'h100);
				write_reg(REG_MAX, 64'hFFFF_0000_0000);
			end
			offer_event(directed[i].size, directed[i].bytes, d);
			sent++;
			if (directed[i].known && d.reset_now !== directed[i].want_reset) begin
				$error("reset_now: expected %0d, got %0d on directed row %0d",
					directed[i].want_reset, d.reset_now, i);
				errors++;
			end
		end
		drain();

		// Random phases. Most events grow a tree with a rising cost per byte,
		// so windows fill, baselines latch and threshold resets happen; one in
		// ten is a fully random event. Trees are not cleared between phases,
		// so window changes land mid-tree.
		cur_size = 48'h4000;
		foreach (phases[p]) begin
			apply_phase(phases[p]);
			calm = phases[p].calm;
			step_cost = $urandom_range(1, 50);
			for (int k = 0; k < phases[p].count; k++) begin
				if (phases[p].squeeze && k == 20)
					hold_req = 1'b1;
				if ($urandom_range(9) == 0) begin
					cur_bytes = $urandom();
					offer_event(48'({$urandom(), $urandom()}), cur_bytes, d);
				end else begin
					cur_size = cur_size + $urandom_range(1, 4096);
					step_cost = step_cost + $urandom_range(0, 40);
					cur_bytes = $urandom_range(0, 2000) + step_cost * $urandom_range(1, 300);
					offer_event(cur_size, cur_bytes, d);
				end
				if (d.reset_now)
					step_cost = $urandom_range(1, 50);
				sent++;
			end
			drain();
			calm = 1'b0;
		end

		repeat (60) @(posedge clk);
		if (pending_decisions.size() != 0) begin
			$error("%0d results never arrived", pending_decisions.size());
			errors++;
		end
		$display("Sent %0d compaction events over %0d register settings; %0d results checked.",
			sent, phases.size() + 2, results_seen);
		$display("The block decided %0d tree resets, %0d mismatches seen.", resets_seen, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
